// File: sv/gcr_pkg.sv
`timescale 1ns / 1ps
package gcr_pkg;

   localparam int MAP_W     = 8;
   localparam int MAP_H     = 8;
   localparam int CELL_SIZE = 64;
   localparam int RAY_COUNT = 60;
   localparam int MAX_STEPS = 8;

   localparam int CELL_Q    = CELL_SIZE * 256;
   localparam int CELL_SH   = $clog2(CELL_Q);
   localparam int MAP_LIM_X = MAP_W * CELL_Q;
   localparam int MAP_LIM_Y = MAP_H * CELL_Q;
   localparam int CX_W      = (MAP_W > 1) ? $clog2(MAP_W) : 1;
   localparam int CY_W      = (MAP_H > 1) ? $clog2(MAP_H) : 1;
   localparam int STEP_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

   localparam int COORD_W   = 17;
   localparam int ANG_W     = 16;
   localparam int TRIG_W    = 18;
   localparam int DIST_W    = 18;
   localparam int HGT_W     = 9;
   localparam int OFS_W     = 8;
   localparam int COL_W     = 6;
   localparam int MAP_BITS  = 64;
   localparam int MAP_IDX_W = 6;

   localparam int G_W       = 20;
   localparam int MA_W      = 20;
   localparam int MB_W      = 19;
   localparam int PROD_W    = 39;
   localparam int DIVN_W    = 36;
   localparam int DIVD_W    = 18;
   localparam int DCNT_W    = $clog2(DIVN_W);
   localparam int SQ_W      = 36;
   localparam int WIDE_W    = 38;
   localparam int REM_W     = 9;

   localparam int ANG_BACK  = 32768;
   localparam int ANG_RIGHT = 16384;
   localparam int ANG_LEFT  = 49152;

   localparam int RAY_START  = 5461;
   localparam int RAY_DEN    = 360;
   localparam int RAY_HALF   = RAY_DEN / 2;
   localparam int RAY_STEP_Q = 65536 / RAY_DEN;
   localparam int RAY_STEP_R = 65536 % RAY_DEN;

   localparam int CORDIC_X0  = 39797;
   localparam int CORDIC_N   = 15;
   localparam int ONE_Q16    = 65536;

   localparam int SCREEN_H   = 320;
   localparam int SCREEN_MID = 160;
   localparam int H_SCALE    = CELL_SIZE * SCREEN_H * 256;
   localparam int DIST_MAX   = 262143;

   typedef logic [4:0] op_type;

   localparam op_type OP_NONE      = 5'd0;
   localparam op_type OP_LOAD      = 5'd1;
   localparam op_type OP_TRIG_RAY  = 5'd2;
   localparam op_type OP_SAVE_CS   = 5'd3;
   localparam op_type OP_H_INIT    = 5'd4;
   localparam op_type OP_V_INIT    = 5'd5;
   localparam op_type OP_W_MUL     = 5'd6;
   localparam op_type OP_W_DIV     = 5'd7;
   localparam op_type OP_W_TEST    = 5'd8;
   localparam op_type OP_SQ_HX     = 5'd9;
   localparam op_type OP_SQ_HY     = 5'd10;
   localparam op_type OP_SQ_VX     = 5'd11;
   localparam op_type OP_SQ_VY     = 5'd12;
   localparam op_type OP_SQ_END    = 5'd13;
   localparam op_type OP_CHOOSE    = 5'd14;
   localparam op_type OP_TRIG_FISH = 5'd15;
   localparam op_type OP_SQRT      = 5'd16;
   localparam op_type OP_DIST_MUL  = 5'd17;
   localparam op_type OP_DIST      = 5'd18;
   localparam op_type OP_H_DIV     = 5'd19;
   localparam op_type OP_HEIGHT    = 5'd20;
   localparam op_type OP_EMIT      = 5'd21;

   typedef struct packed {
      logic cordic_busy;
      logic div_busy;
      logic sqrt_busy;
      logic h_en;
      logic v_en;
      logic wall;
      logic last_step;
      logic horiz;
      logic any_hit;
      logic dist_zero;
      logic last_ray;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [OFS_W-1:0]   line_offset;
      logic [HGT_W-1:0]   line_height;
      logic [DIST_W-1:0]  distance;
      logic [COORD_W-1:0] hit_y;
      logic [COORD_W-1:0] hit_x;
      logic               wall_is_vertical;
      logic               hit_found;
      logic [COL_W-1:0]   column;
      logic               last;
   } result_type;

   function automatic logic [13:0] arc_atan(input logic [3:0] idx);
      logic [13:0] v;
      case (idx)
         4'd0:    v = 14'd8192;
         4'd1:    v = 14'd4836;
         4'd2:    v = 14'd2555;
         4'd3:    v = 14'd1297;
         4'd4:    v = 14'd651;
         4'd5:    v = 14'd326;
         4'd6:    v = 14'd163;
         4'd7:    v = 14'd81;
         4'd8:    v = 14'd41;
         4'd9:    v = 14'd20;
         4'd10:   v = 14'd10;
         4'd11:   v = 14'd5;
         4'd12:   v = 14'd3;
         4'd13:   v = 14'd1;
         4'd14:   v = 14'd1;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

endpackage

// File: sv/gcr_cordic.sv
`timescale 1ns / 1ps
module gcr_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [gcr_pkg::ANG_W-1:0]          angle,
   output logic                               busy,
   output logic signed [gcr_pkg::TRIG_W-1:0]  cos_out,
   output logic signed [gcr_pkg::TRIG_W-1:0]  sin_out
);
   import gcr_pkg::*;

   localparam int XW = 20;

   logic signed [XW-1:0]     x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [TRIG_W-1:0] z_ff, z_in, za;
   logic [3:0]               i_ff, i_in;
   logic [1:0]               q_ff, q_in;
   logic                     busy_ff, busy_in;
   logic signed [TRIG_W-1:0] xc, yc;

   // shift toward zero, as a signed divide by a power of two
   function automatic logic signed [XW-1:0] tdiv(input logic signed [XW-1:0] v,
                                                 input logic [3:0] n);
      logic signed [XW-1:0] sh;
      logic [XW-1:0]        mask;
      sh   = v >>> n;
      mask = ~({XW{1'b1}} << n);
      return sh + ((v[XW-1] && (|(v & mask))) ? XW'(1) : XW'(0));
   endfunction

   function automatic logic signed [TRIG_W-1:0] clamp(input logic signed [XW-1:0] v);
      logic signed [TRIG_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > XW'(ONE_Q16)) begin
         r = TRIG_W'(ONE_Q16);
      end else begin
         r = TRIG_W'(v);
      end
      return r;
   endfunction

   assign dx = tdiv(y_ff, i_ff);
   assign dy = tdiv(x_ff, i_ff);
   assign za = signed'(TRIG_W'(arc_atan(i_ff)));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      q_in    = q_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in    = XW'(CORDIC_X0);
         y_in    = '0;
         z_in    = signed'(TRIG_W'(angle[ANG_W-3:0]));
         q_in    = angle[ANG_W-1:ANG_W-2];
         i_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[TRIG_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - za;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + za;
         end
         if (i_ff == 4'(CORDIC_N - 1)) begin
            busy_in = 1'b0;
         end else begin
            i_in = i_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      i_ff <= i_in;
      q_ff <= q_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign xc   = clamp(x_ff);
   assign yc   = clamp(y_ff);
   assign busy = busy_ff;

   always_comb begin
      unique case (q_ff)
         2'd0: begin
            cos_out = xc;
            sin_out = yc;
         end
         2'd1: begin
            cos_out = -yc;
            sin_out = xc;
         end
         2'd2: begin
            cos_out = -xc;
            sin_out = -yc;
         end
         default: begin
            cos_out = yc;
            sin_out = -xc;
         end
      endcase
   end

endmodule

// File: sv/gcr_div.sv
`timescale 1ns / 1ps
module gcr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gcr_pkg::DIVN_W-1:0]  dividend,
   input  logic [gcr_pkg::DIVD_W-1:0]  divisor,
   output logic                        busy,
   output logic [gcr_pkg::DIVN_W-1:0]  quotient
);
   import gcr_pkg::*;

   logic [DIVN_W-1:0] quo_ff;
   logic [DIVD_W-1:0] rem_ff, dvs_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic              busy_ff;
   logic [DIVD_W:0]   trial, diff;

   assign trial = {rem_ff, quo_ff[DIVN_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   // one quotient bit per cycle, restoring
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + DCNT_W'(1);
         if (trial >= {1'b0, dvs_ff}) begin
            rem_ff <= diff[DIVD_W-1:0];
            quo_ff <= {quo_ff[DIVN_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DIVD_W-1:0];
            quo_ff <= {quo_ff[DIVN_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == DCNT_W'(DIVN_W - 1)) begin
         busy_ff <= 1'b0;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/gcr_dp.sv
`timescale 1ns / 1ps
module gcr_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  gcr_pkg::op_type              op,
   output gcr_pkg::status_type          st,
   input  logic [gcr_pkg::COORD_W-1:0]  pos_x,
   input  logic [gcr_pkg::COORD_W-1:0]  pos_y,
   input  logic [gcr_pkg::ANG_W-1:0]    view_angle,
   input  logic                         csr_wr_en,
   input  logic [gcr_pkg::MAP_BITS-1:0] csr_wr_data,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output gcr_pkg::result_type          rsp
);
   import gcr_pkg::*;

   logic [MAP_BITS-1:0]      map_ff;
   logic [COORD_W-1:0]       px_ff, py_ff;
   logic [ANG_W-1:0]         va_ff, ray_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [REM_W:0]           rem_sum;
   logic                     rem_wrap;
   logic [COL_W-1:0]         col_ff;
   logic signed [TRIG_W-1:0] c_ff, s_ff, cos_w, sin_w;

   logic                     horiz_ff;
   logic [COORD_W-1:0]       pg_ff, po_ff;
   logic signed [TRIG_W-1:0] dg_ff, dor_ff;
   logic signed [G_W-1:0]    g_ff, diff_g;
   logic [STEP_W-1:0]        k_ff;
   logic                     qneg_ff;

   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_ff, abs_prod;
   logic [SQ_W-1:0]          acc_ff, sqh_ff, sqv_ff, sq_ff, prod_lo;

   logic                     hh_ff, vh_ff, vert_ff;
   logic [COORD_W-1:0]       hx_ff, hy_ff, vx_ff, vy_ff, cx_ff, cy_ff;
   logic signed [COORD_W:0]  dxh, dyh, dxv, dyv;

   logic [SQ_W-1:0]          sv_ff, sres_ff, sbit_ff;
   logic [SQ_W:0]            strial;

   logic [DIST_W-1:0]        dist_ff;
   logic [PROD_W-18:0]       dist_hi;
   logic [HGT_W-1:0]         h_ff;

   logic                     cordic_start, cordic_busy;
   logic [ANG_W-1:0]         cordic_ang;
   logic                     div_start, div_busy;
   logic [DIVN_W-1:0]        div_num, quo;
   logic [DIVD_W-1:0]        div_den, abs_dg;

   logic signed [WIDE_W-1:0] q_w, q_s, o_s, g_w, x_w, y_w;
   logic                     in_map, wall;
   logic [MAP_IDX_W-1:0]     cell_idx;
   logic [TRIG_W-2:0]        cc_pos;

   logic                     out_valid_ff;
   result_type               out_ff;

   function automatic logic signed [G_W-1:0] first_line(input logic [COORD_W-1:0] p,
                                                        input logic neg);
      logic signed [G_W-1:0] base;
      base = signed'(G_W'({p[COORD_W-1:CELL_SH], CELL_SH'(0)}));
      return neg ? base - G_W'(1) : base + G_W'(CELL_Q);
   endfunction

   gcr_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (cordic_ang),
      .busy    (cordic_busy),
      .cos_out (cos_w),
      .sin_out (sin_w)
   );

   gcr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
      end else if (csr_wr_en) begin
         map_ff <= csr_wr_data;
      end
   end

   assign cordic_start = (op == OP_TRIG_RAY) || (op == OP_TRIG_FISH);
   assign cordic_ang   = (op == OP_TRIG_RAY) ? ray_ff : va_ff - ray_ff;

   assign abs_prod = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
   assign abs_dg   = dg_ff[TRIG_W-1] ? DIVD_W'(-dg_ff) : DIVD_W'(dg_ff);
   assign div_start = (op == OP_W_DIV) || (op == OP_H_DIV);
   assign div_num   = (op == OP_W_DIV) ? abs_prod[DIVN_W-1:0] : DIVN_W'(H_SCALE);
   assign div_den   = (op == OP_W_DIV) ? abs_dg : dist_ff;

   // crossing point along the walk
   assign diff_g = g_ff - signed'(G_W'(pg_ff));
   assign q_w    = signed'(WIDE_W'(quo));
   assign q_s    = qneg_ff ? -q_w : q_w;
   assign o_s    = signed'(WIDE_W'(po_ff)) + q_s;
   assign g_w    = WIDE_W'(g_ff);
   assign x_w    = horiz_ff ? o_s : g_w;
   assign y_w    = horiz_ff ? g_w : o_s;
   assign in_map = !x_w[WIDE_W-1] && !y_w[WIDE_W-1]
                   && (x_w < WIDE_W'(MAP_LIM_X)) && (y_w < WIDE_W'(MAP_LIM_Y));
   assign cell_idx = MAP_IDX_W'(int'(y_w[CELL_SH +: CY_W]) * MAP_W
                                + int'(x_w[CELL_SH +: CX_W]));
   assign wall   = in_map && map_ff[cell_idx];

   assign dxh = signed'({1'b0, hx_ff}) - signed'({1'b0, px_ff});
   assign dyh = signed'({1'b0, hy_ff}) - signed'({1'b0, py_ff});
   assign dxv = signed'({1'b0, vx_ff}) - signed'({1'b0, px_ff});
   assign dyv = signed'({1'b0, vy_ff}) - signed'({1'b0, py_ff});
   assign cc_pos = cos_w[TRIG_W-1] ? '0 : cos_w[TRIG_W-2:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op)
         OP_W_MUL: begin
            mul_a = MA_W'(diff_g);
            mul_b = MB_W'(dor_ff);
         end
         OP_SQ_HX: begin
            mul_a = MA_W'(dxh);
            mul_b = MB_W'(dxh);
         end
         OP_SQ_HY: begin
            mul_a = MA_W'(dyh);
            mul_b = MB_W'(dyh);
         end
         OP_SQ_VX: begin
            mul_a = MA_W'(dxv);
            mul_b = MB_W'(dxv);
         end
         OP_SQ_VY: begin
            mul_a = MA_W'(dyv);
            mul_b = MB_W'(dyv);
         end
         OP_DIST_MUL: begin
            mul_a = signed'({1'b0, sres_ff[MA_W-2:0]});
            mul_b = signed'(MB_W'(cc_pos));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_lo  = prod_ff[SQ_W-1:0];
   assign dist_hi  = prod_ff[PROD_W-2:16];
   assign rem_sum  = {1'b0, rem_ff} + (REM_W+1)'(RAY_STEP_R);
   assign rem_wrap = rem_sum >= (REM_W+1)'(RAY_DEN);
   assign strial   = {1'b0, sres_ff} + {1'b0, sbit_ff};

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (|sbit_ff) begin
         if ({1'b0, sv_ff} >= strial) begin
            sv_ff   <= sv_ff - strial[SQ_W-1:0];
            sres_ff <= (sres_ff >> 1) + sbit_ff;
         end else begin
            sres_ff <= sres_ff >> 1;
         end
      end
      unique case (op)
         OP_LOAD: begin
            px_ff  <= pos_x;
            py_ff  <= pos_y;
            va_ff  <= view_angle;
            ray_ff <= view_angle - ANG_W'(RAY_START);
            rem_ff <= REM_W'(RAY_HALF);
            col_ff <= '0;
         end
         OP_SAVE_CS: begin
            c_ff <= cos_w;
            s_ff <= sin_w;
         end
         OP_H_INIT: begin
            horiz_ff <= 1'b1;
            pg_ff    <= py_ff;
            po_ff    <= px_ff;
            dg_ff    <= s_ff;
            dor_ff   <= c_ff;
            g_ff     <= first_line(py_ff, s_ff[TRIG_W-1]);
            k_ff     <= '0;
         end
         OP_V_INIT: begin
            horiz_ff <= 1'b0;
            pg_ff    <= px_ff;
            po_ff    <= py_ff;
            dg_ff    <= c_ff;
            dor_ff   <= s_ff;
            g_ff     <= first_line(px_ff, c_ff[TRIG_W-1]);
            k_ff     <= '0;
         end
         OP_W_DIV: begin
            qneg_ff <= prod_ff[PROD_W-1] ^ dg_ff[TRIG_W-1];
         end
         OP_W_TEST: begin
            if (wall) begin
               if (horiz_ff) begin
                  hx_ff <= x_w[COORD_W-1:0];
                  hy_ff <= y_w[COORD_W-1:0];
               end else begin
                  vx_ff <= x_w[COORD_W-1:0];
                  vy_ff <= y_w[COORD_W-1:0];
               end
            end else begin
               k_ff <= k_ff + STEP_W'(1);
               g_ff <= dg_ff[TRIG_W-1] ? g_ff - G_W'(CELL_Q) : g_ff + G_W'(CELL_Q);
            end
         end
         OP_SQ_HY: acc_ff <= prod_lo;
         OP_SQ_VX: sqh_ff <= acc_ff + prod_lo;
         OP_SQ_VY: acc_ff <= prod_lo;
         OP_SQ_END: sqv_ff <= acc_ff + prod_lo;
         OP_CHOOSE: begin
            if (vh_ff && (!hh_ff || sqv_ff <= sqh_ff)) begin
               vert_ff <= 1'b1;
               cx_ff   <= vx_ff;
               cy_ff   <= vy_ff;
               sq_ff   <= sqv_ff;
            end else begin
               vert_ff <= 1'b0;
               cx_ff   <= hx_ff;
               cy_ff   <= hy_ff;
               sq_ff   <= sqh_ff;
            end
         end
         OP_SQRT: begin
            sv_ff   <= sq_ff;
            sres_ff <= '0;
         end
         OP_DIST: begin
            dist_ff <= (dist_hi > (PROD_W-17)'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                           : dist_hi[DIST_W-1:0];
         end
         OP_HEIGHT: begin
            if (dist_ff == '0 || quo > DIVN_W'(SCREEN_H)) begin
               h_ff <= HGT_W'(SCREEN_H);
            end else begin
               h_ff <= quo[HGT_W-1:0];
            end
         end
         OP_EMIT: begin
            col_ff <= col_ff + COL_W'(1);
            rem_ff <= rem_wrap ? REM_W'(rem_sum - (REM_W+1)'(RAY_DEN)) : rem_sum[REM_W-1:0];
            ray_ff <= ray_ff + ANG_W'(RAY_STEP_Q) + ANG_W'(rem_wrap);
         end
         default: begin
         end
      endcase
   end

   // control state: hit flags, root bit, output register
   always_ff @(posedge clock) begin
      if (reset) begin
         hh_ff        <= 1'b0;
         vh_ff        <= 1'b0;
         sbit_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (op == OP_TRIG_RAY) begin
            hh_ff <= 1'b0;
            vh_ff <= 1'b0;
         end else if (op == OP_W_TEST && wall) begin
            if (horiz_ff) begin
               hh_ff <= 1'b1;
            end else begin
               vh_ff <= 1'b1;
            end
         end
         if (op == OP_SQRT) begin
            sbit_ff <= SQ_W'(1) << (SQ_W - 2);
         end else begin
            sbit_ff <= sbit_ff >> 2;
         end
         if (op == OP_EMIT) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op == OP_EMIT) begin
         out_ff.column <= col_ff;
         out_ff.last   <= (col_ff == COL_W'(RAY_COUNT - 1));
         if (hh_ff || vh_ff) begin
            out_ff.hit_found        <= 1'b1;
            out_ff.wall_is_vertical <= vert_ff;
            out_ff.hit_x            <= cx_ff;
            out_ff.hit_y            <= cy_ff;
            out_ff.distance         <= dist_ff;
            out_ff.line_height      <= h_ff;
            out_ff.line_offset      <= OFS_W'(SCREEN_MID) - OFS_W'(h_ff >> 1);
         end else begin
            out_ff.hit_found        <= 1'b0;
            out_ff.wall_is_vertical <= 1'b0;
            out_ff.hit_x            <= px_ff;
            out_ff.hit_y            <= py_ff;
            out_ff.distance         <= DIST_W'(DIST_MAX);
            out_ff.line_height      <= '0;
            out_ff.line_offset      <= OFS_W'(SCREEN_MID);
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   always_comb begin
      st.cordic_busy = cordic_busy;
      st.div_busy    = div_busy;
      st.sqrt_busy   = |sbit_ff;
      st.h_en        = (ray_ff != '0) && (ray_ff != ANG_W'(ANG_BACK)) && (s_ff != '0);
      st.v_en        = (ray_ff != ANG_W'(ANG_RIGHT)) && (ray_ff != ANG_W'(ANG_LEFT))
                       && (c_ff != '0);
      st.wall        = wall;
      st.last_step   = (k_ff == STEP_W'(MAX_STEPS - 1));
      st.horiz       = horiz_ff;
      st.any_hit     = hh_ff || vh_ff;
      st.dist_zero   = (dist_ff == '0);
      st.last_ray    = (col_ff == COL_W'(RAY_COUNT - 1));
      st.out_free    = !out_valid_ff || rsp_ready;
   end

endmodule

// File: sv/gcr_ctrl.sv
`timescale 1ns / 1ps
module gcr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  gcr_pkg::status_type st,
   output gcr_pkg::op_type     op
);
   import gcr_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_RAY    = 5'd1;
   localparam logic [4:0] S_RAY_W  = 5'd2;
   localparam logic [4:0] S_H_INIT = 5'd3;
   localparam logic [4:0] S_V_INIT = 5'd4;
   localparam logic [4:0] S_MUL    = 5'd5;
   localparam logic [4:0] S_DIV    = 5'd6;
   localparam logic [4:0] S_DIV_W  = 5'd7;
   localparam logic [4:0] S_TEST   = 5'd8;
   localparam logic [4:0] S_POST   = 5'd9;
   localparam logic [4:0] S_SQ_HX  = 5'd10;
   localparam logic [4:0] S_SQ_HY  = 5'd11;
   localparam logic [4:0] S_SQ_VX  = 5'd12;
   localparam logic [4:0] S_SQ_VY  = 5'd13;
   localparam logic [4:0] S_SQ_END = 5'd14;
   localparam logic [4:0] S_CHOOSE = 5'd15;
   localparam logic [4:0] S_FISH   = 5'd16;
   localparam logic [4:0] S_FISH_W = 5'd17;
   localparam logic [4:0] S_SQRT   = 5'd18;
   localparam logic [4:0] S_SQRT_W = 5'd19;
   localparam logic [4:0] S_DMUL   = 5'd20;
   localparam logic [4:0] S_DIST   = 5'd21;
   localparam logic [4:0] S_HDIV   = 5'd22;
   localparam logic [4:0] S_HDIV_W = 5'd23;
   localparam logic [4:0] S_HGT    = 5'd24;
   localparam logic [4:0] S_EMIT   = 5'd25;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = S_RAY;
            end
         end
         S_RAY: begin
            op       = OP_TRIG_RAY;
            state_in = S_RAY_W;
         end
         S_RAY_W: begin
            if (!st.cordic_busy) begin
               op       = OP_SAVE_CS;
               state_in = S_H_INIT;
            end
         end
         S_H_INIT: begin
            op       = OP_H_INIT;
            state_in = st.h_en ? S_MUL : S_V_INIT;
         end
         S_V_INIT: begin
            op       = OP_V_INIT;
            state_in = st.v_en ? S_MUL : S_POST;
         end
         S_MUL: begin
            op       = OP_W_MUL;
            state_in = S_DIV;
         end
         S_DIV: begin
            op       = OP_W_DIV;
            state_in = S_DIV_W;
         end
         S_DIV_W: begin
            if (!st.div_busy) begin
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            op = OP_W_TEST;
            if (st.wall || st.last_step) begin
               state_in = st.horiz ? S_V_INIT : S_POST;
            end else begin
               state_in = S_MUL;
            end
         end
         S_POST: state_in = st.any_hit ? S_SQ_HX : S_EMIT;
         S_SQ_HX: begin
            op       = OP_SQ_HX;
            state_in = S_SQ_HY;
         end
         S_SQ_HY: begin
            op       = OP_SQ_HY;
            state_in = S_SQ_VX;
         end
         S_SQ_VX: begin
            op       = OP_SQ_VX;
            state_in = S_SQ_VY;
         end
         S_SQ_VY: begin
            op       = OP_SQ_VY;
            state_in = S_SQ_END;
         end
         S_SQ_END: begin
            op       = OP_SQ_END;
            state_in = S_CHOOSE;
         end
         S_CHOOSE: begin
            op       = OP_CHOOSE;
            state_in = S_FISH;
         end
         S_FISH: begin
            op       = OP_TRIG_FISH;
            state_in = S_FISH_W;
         end
         S_FISH_W: begin
            if (!st.cordic_busy) begin
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            op       = OP_SQRT;
            state_in = S_SQRT_W;
         end
         S_SQRT_W: begin
            if (!st.sqrt_busy) begin
               state_in = S_DMUL;
            end
         end
         S_DMUL: begin
            op       = OP_DIST_MUL;
            state_in = S_DIST;
         end
         S_DIST: begin
            op       = OP_DIST;
            state_in = S_HDIV;
         end
         S_HDIV: begin
            if (st.dist_zero) begin
               state_in = S_HGT;
            end else begin
               op       = OP_H_DIV;
               state_in = S_HDIV_W;
            end
         end
         S_HDIV_W: begin
            if (!st.div_busy) begin
               state_in = S_HGT;
            end
         end
         S_HGT: begin
            op       = OP_HEIGHT;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (st.out_free) begin
               op       = OP_EMIT;
               state_in = st.last_ray ? S_IDLE : S_RAY;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// File: sv/grid_ray_caster.sv
`timescale 1ns / 1ps
// Grid ray caster. One request carries a player pose; the block answers with
// 60 column results, one per ray, the final one flagged by rsp_tlast. Rays are
// handled one at a time by a shared 15-step CORDIC, a shared radix-2 divider
// and a 2-bit-per-cycle square root. The cost of each grid crossing is
// dominated by the divider, and each walk tests up to 8 crossings. A ray that
// hits a wall then goes on to the fisheye CORDIC, the square root and the
// height division. The time a ray and a pose take depends on how far the rays
// travel before a wall, and on any stalls of a column on rsp_tready.
// A new request is taken once the last column of the frame is in the output
// register. The wall map is written through csr_wr_en/csr_wr_data; the user
// must write it only while idle, which the block itself does not enforce.
module grid_ray_caster (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // pos_x, pos_y, view_angle, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // column, hit_found, wall_is_vertical, hit_x,
                                    // hit_y, distance, line_height, line_offset, pad
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);
   import gcr_pkg::*;

   op_type     op;
   status_type st;
   result_type rsp;

   gcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .st        (st),
      .op        (op)
   );

   gcr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .st          (st),
      .pos_x       (req_tdata[16:0]),
      .pos_y       (req_tdata[33:17]),
      .view_angle  (req_tdata[49:34]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp         (rsp)
   );

   assign rsp_tdata = {3'b000, rsp.line_offset, rsp.line_height, rsp.distance,
                       rsp.hit_y, rsp.hit_x, rsp.wall_is_vertical, rsp.hit_found,
                       rsp.column};
   assign rsp_tlast = rsp.last;

endmodule

// File: tb/sv/grid_ray_caster_tb.sv
`timescale 1ns / 1ps
module grid_ray_caster_tb;
   import gcr_pkg::*;

   localparam longint CYCLE_LIMIT = 60000000;

   typedef struct {
      logic [16:0] pos_x;
      logic [16:0] pos_y;
      logic [15:0] view_angle;
   } pose_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [63:0] csr_wr_data = '0;

   pose_type   pose_q[$];
   result_type column_q[$];
   logic [63:0] wall_map = '0;
   bit          idling = 1'b1;
   bit          req_taken = 1'b0;
   int          fail_count = 0;
   int          poses_done = 0;
   int          columns_checked = 0;
   int          hits_seen = 0;
   longint      cycles = 0;

   grid_ray_caster dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // signed Q1.16 cos and sin of a binary angle
   function automatic void cos_sin(input int unsigned ang, output longint c, output longint s);
      longint atan_q[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
      longint x, y, z, dx, dy;
      x = 39797;
      y = 0;
      z = ang & 16'h3FFF;
      for (int i = 0; i < 15; i++) begin
         dx = y / (64'sd1 <<< i);
         dy = x / (64'sd1 <<< i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_q[i];
         end else begin
            x += dx; y -= dy; z += atan_q[i];
         end
      end
      if (x < 0) x = 0;
      if (x > ONE_Q16) x = ONE_Q16;
      if (y < 0) y = 0;
      if (y > ONE_Q16) y = ONE_Q16;
      case ((ang >> 14) & 3)
         0: begin c = x;  s = y;  end
         1: begin c = -y; s = x;  end
         2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic bit wall_at(input longint x, input longint y);
      longint cx, cy;
      if (x < 0 || y < 0) return 0;
      cx = x / CELL_Q;
      cy = y / CELL_Q;
      if (cx >= MAP_W || cy >= MAP_H) return 0;
      return wall_map[cy * MAP_W + cx];
   endfunction

   // march across lines normal to the g axis; horiz means g is y
   function automatic bit grid_walk(input longint pg, input longint po, input longint dg,
                                    input longint dother, input bit horiz,
                                    output longint hx, output longint hy);
      longint g0, stride, g, o, x, y;
      g0 = (pg / CELL_Q) * CELL_Q;
      if (dg < 0) begin
         g0 -= 1; stride = -CELL_Q;
      end else begin
         g0 += CELL_Q; stride = CELL_Q;
      end
      hx = 0;
      hy = 0;
      for (int k = 0; k < MAX_STEPS; k++) begin
         g = g0 + k * stride;
         o = po + ((g - pg) * dother) / dg;
         x = horiz ? o : g;
         y = horiz ? g : o;
         if (wall_at(x, y)) begin
            hx = x; hy = y;
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b; res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   task automatic cast_frame(input pose_type p);
      longint px, py, c, s, cc, sc, hx, hy, vx, vy, cx, cy;
      longint unsigned sqh, sqv, sq, span, h;
      int unsigned ray;
      bit hh, vh, vert;
      result_type res;
      px = p.pos_x;
      py = p.pos_y;
      for (int r = 0; r < RAY_COUNT; r++) begin
         ray = (p.view_angle + (r * 65536 + 180) / 360 + 65536 - 5461) & 16'hFFFF;
         cos_sin(ray, c, s);
         hh = 0; vh = 0; vert = 0;
         cx = px; cy = py;
         span = DIST_MAX; h = 0;
         if (ray != 0 && ray != ANG_BACK && s != 0)
            hh = grid_walk(py, px, s, c, 1, hx, hy);
         if (ray != ANG_RIGHT && ray != ANG_LEFT && c != 0)
            vh = grid_walk(px, py, c, s, 0, vx, vy);
         if (hh || vh) begin
            sqh = (hx - px) * (hx - px) + (hy - py) * (hy - py);
            sqv = (vx - px) * (vx - px) + (vy - py) * (vy - py);
            vert = vh && (!hh || sqv <= sqh);
            if (vert) begin
               cx = vx; cy = vy; sq = sqv;
            end else begin
               cx = hx; cy = hy; sq = sqh;
            end
            cos_sin((p.view_angle - ray) & 16'hFFFF, cc, sc);
            if (cc < 0) cc = 0;
            span = (int_sqrt(sq) * cc) >> 16;
            if (span > DIST_MAX) span = DIST_MAX;
            h = (span == 0) ? SCREEN_H : H_SCALE / span;
            if (h > SCREEN_H) h = SCREEN_H;
         end
         res.column           = COL_W'(r);
         res.hit_found        = hh || vh;
         res.wall_is_vertical = vert;
         res.hit_x            = cx[16:0];
         res.hit_y            = cy[16:0];
         res.distance         = span[17:0];
         res.line_height      = h[8:0];
         res.line_offset      = OFS_W'(SCREEN_MID - h / 2);
         res.last             = (r == RAY_COUNT - 1);
         column_q.push_back(res);
      end
   endtask

   // request side
   always @(negedge clock) begin
      if (req_tvalid && !req_taken) begin
         // hold the current request
      end else if (!reset && pose_q.size() > 0 && !(idling && $urandom_range(99) < 37)) begin
         pose_type p;
         p = pose_q.pop_front();
         req_tdata  <= {6'd0, p.view_angle, p.pos_y, p.pos_x};
         req_tvalid <= 1'b1;
      end else begin
         req_tvalid <= 1'b0;
      end
      req_taken = 1'b0;
      rsp_tready <= !reset && !(idling && $urandom_range(99) < 37);
   end

   // accept requests and check columns
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("grid_ray_caster_tb: FAIL");
         $finish;
      end
      if (!reset && req_tvalid && req_tready) begin
         pose_type p;
         p.pos_x      = req_tdata[16:0];
         p.pos_y      = req_tdata[33:17];
         p.view_angle = req_tdata[49:34];
         cast_frame(p);
         req_taken = 1'b1;
         poses_done++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_type want;
         if (column_q.size() == 0) begin
            $error("column with no pending frame: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = column_q.pop_front();
            columns_checked++;
            if (rsp_tdata[6]) hits_seen++;
            if (rsp_tdata[5:0] != want.column) begin
               $error("column: expected %0d, got %0d", want.column, rsp_tdata[5:0]);
               fail_count++;
            end
            if (rsp_tdata[6] != want.hit_found) begin
               $error("hit_found: expected %0d, got %0d", want.hit_found, rsp_tdata[6]);
               fail_count++;
            end
            if (rsp_tdata[7] != want.wall_is_vertical) begin
               $error("wall_is_vertical: expected %0d, got %0d", want.wall_is_vertical,
                      rsp_tdata[7]);
               fail_count++;
            end
            if (rsp_tdata[24:8] != want.hit_x) begin
               $error("hit_x: expected %0d, got %0d", want.hit_x, rsp_tdata[24:8]);
               fail_count++;
            end
            if (rsp_tdata[41:25] != want.hit_y) begin
               $error("hit_y: expected %0d, got %0d", want.hit_y, rsp_tdata[41:25]);
               fail_count++;
            end
            if (rsp_tdata[59:42] != want.distance) begin
               $error("distance: expected %0d, got %0d", want.distance, rsp_tdata[59:42]);
               fail_count++;
            end
            if (rsp_tdata[68:60] != want.line_height) begin
               $error("line_height: expected %0d, got %0d", want.line_height,
                      rsp_tdata[68:60]);
               fail_count++;
            end
            if (rsp_tdata[76:69] != want.line_offset) begin
               $error("line_offset: expected %0d, got %0d", want.line_offset,
                      rsp_tdata[76:69]);
               fail_count++;
            end
            if (rsp_tlast != want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   task automatic add_pose(input logic [16:0] x, input logic [16:0] y, input logic [15:0] a);
      pose_type p;
      p.pos_x = x;
      p.pos_y = y;
      p.view_angle = a;
      pose_q.push_back(p);
   endtask

   task automatic add_random(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) == 0)
            // park near a cell center
            add_pose(17'(($urandom_range(7) << 14) + 8192 + $urandom_range(255)),
                     17'(($urandom_range(7) << 14) + 8192 + $urandom_range(255)),
                     16'($urandom()));
         else
            add_pose(17'($urandom_range(131071)), 17'($urandom_range(131071)),
                     16'($urandom_range(65535)));
      end
   endtask

   // wait until the block has drained, then load a new map
   task automatic load_map(input logic [63:0] cells);
      wait (pose_q.size() == 0 && !req_tvalid && column_q.size() == 0);
      repeat (50) @(negedge clock);
      csr_wr_data <= cells;
      csr_wr_en   <= 1'b1;
      wall_map = cells;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      load_map(64'hFF81_8181_8181_81FF);
      add_pose(17'd0, 17'd0, 16'd0);
      add_pose(17'd131071, 17'd131071, 16'd65535);
      add_pose(17'd65536, 17'd65536, 16'd5461);      // first ray straight along +x
      add_pose(17'd65536, 17'd65536, 16'd21845);     // first ray straight down
      add_pose(17'd65536, 17'd65536, 16'd38229);     // first ray along -x
      add_pose(17'd65536, 17'd65536, 16'd54613);     // first ray straight up
      add_pose(17'd65536, 17'd65536, 16'd16384);
      add_pose(17'd65536, 17'd65536, 16'd32768);
      add_pose(17'd65536, 17'd65536, 16'd49152);
      add_pose(17'd16384, 17'd16384, 16'd49152);     // standing on a grid line, wall above
      add_pose(17'd16384, 17'd16384, 16'd32768);
      add_pose(17'd16385, 17'd16385, 16'd40960);
      add_pose(17'd114687, 17'd114687, 16'd8192);
      add_pose(17'd131071, 17'd0, 16'd24576);
      add_pose(17'd0, 17'd131071, 16'd57344);
      add_pose(17'd20000, 17'd100000, 16'd12345);
      add_random(20);

      load_map(64'd0);
      add_pose(17'd65536, 17'd65536, 16'd0);
      add_random(20);

      load_map(64'hFFFF_FFFF_FFFF_FFFF);
      add_random(30);

      // no gaps on either side for this map
      load_map({$urandom(), $urandom()});
      idling = 1'b0;
      add_random(50);
      load_map({$urandom(), $urandom()} & {$urandom(), $urandom()});
      idling = 1'b1;
      add_random(50);
      load_map({$urandom(), $urandom()} | 64'hFF81_8181_8181_81FF);
      add_random(62);
      add_pose(17'd40000, 17'd90000, 16'd30000);

      wait (pose_q.size() == 0 && !req_tvalid && column_q.size() == 0);
      repeat (200) @(negedge clock);
      $display("Cast %0d poses over 6 wall maps; checked %0d columns, %0d of them hits.",
               poses_done, columns_checked, hits_seen);
      if (fail_count == 0 && column_q.size() == 0)
         $display("grid_ray_caster_tb: PASS");
      else
         $display("grid_ray_caster_tb: FAIL");
      $finish;
   end

endmodule
